>>> sv/tlbpt_pkg.sv
// Package for the page translation unit: item kinds, status codes, rights bits,
// sequencer states and preset mappings. No dependencies.
package tlbpt_pkg;

   localparam int VA_BITS   = 48;
   localparam int PAGE_BITS = 36;

   typedef enum logic [1:0] {
      KIND_TRANSLATE = 2'd0,
      KIND_ADD       = 2'd1,
      KIND_FLUSH     = 2'd2,
      KIND_NONE      = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_TRANSLATED = 3'd0,
      ST_FAULT      = 3'd1,
      ST_DENIED     = 3'd2,
      ST_APPENDED   = 3'd3,
      ST_REPLACED   = 3'd4,
      ST_FULL       = 3'd5,
      ST_FLUSHED    = 3'd6
   } status_type;

   localparam logic [1:0] ACC_WRITE = 2'd1;
   localparam logic [1:0] ACC_NONE  = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TLB,      // step through TLB entries
      S_WALK,     // read page table entry
      S_WCMP,     // compare registered entry
      S_DIRTY,    // search first entry with page for dirty mark
      S_DCMP,
      S_ADD,      // search for existing page
      S_ACMP,
      S_ADDW,     // write entry
      S_DONE
   } state_type;

   localparam int PRESETS = 5;

   function automatic logic [PAGE_BITS-1:0] preset_phys(input logic [2:0] i);
      logic [PAGE_BITS-1:0] p;
      unique case (i)
         3'd0:    p = 36'h30000;
         3'd1:    p = 36'h21000;
         3'd2:    p = 36'h45000;
         3'd3:    p = 36'h72000;
         default: p = 36'h80000;
      endcase
      return p;
   endfunction

   function automatic logic [2:0] preset_rights(input logic [2:0] i);
      logic [2:0] r;
      unique case (i)
         3'd0:    r = 3'b111;
         3'd1:    r = 3'b011;
         3'd2:    r = 3'b101;
         3'd3:    r = 3'b001;
         default: r = 3'b011;
      endcase
      return r;
   endfunction

   // Request/response between sequencer and table memory
   typedef struct packed {
      logic rd;
      logic wr_entry;    // whole-entry write (add)
      logic set_acc;
      logic set_dirty;
   } pt_cmd_type;

endpackage

>>> sv/tlb_page_translation_unit.sv
// Page translation unit top level: TLB registers, sequencer, counters, table.
// Uses tlbpt_pkg and tlbpt_table. A translation searches the TLB slots in order, then on a miss
// walks the table entries in order, faulting past the last; a granted write then searches the
// table for the page to set its dirty mark. An add searches the table to replace or append.
// One transaction at a time, busy high meanwhile; one result strobed for one cycle, the
// receiver cannot stall. Reset: synchronous; presets load after reset with busy high.
module tlb_page_translation_unit #(
   parameter int TLB_ENTRIES = 16,
   parameter int TABLE_ENTRIES = 128,
   parameter int OFFSET_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [47:0] req_virtual_address,
   input  logic [1:0]  req_access,
   input  logic [35:0] req_virtual_page,
   input  logic [35:0] req_physical_page,
   input  logic [2:0]  req_permissions,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [47:0] rsp_physical_address,
   output logic        rsp_tlb_hit,
   output logic [31:0] rsp_translation_count,
   output logic [31:0] rsp_hit_count,
   output logic [31:0] rsp_miss_count,
   output logic [31:0] rsp_fault_count
);
   localparam int PB = tlbpt_pkg::PAGE_BITS;
   localparam int IB = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CB = $clog2(TABLE_ENTRIES + 1);
   localparam int TB = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int TCB = $clog2(TLB_ENTRIES + 1);

   tlbpt_pkg::state_type state_ff, state_in;
   logic [1:0]  kind_ff;
   logic [1:0]  acc_ff;
   logic [PB-1:0] page_ff;
   logic [OFFSET_BITS-1:0] off_ff;
   logic [PB-1:0] add_pp_ff;
   logic [2:0]  perm_ff, rights_ff, rights_in;
   logic [PB-1:0] res_pp_ff, res_pp_in;
   logic [CB-1:0] idx_ff, idx_in, count_ff, count_in;
   logic [TCB-1:0] tidx_ff, tidx_in;
   logic [TB-1:0] next_ff, next_in;
   logic [PB-1:0] tlb_vp_ff [TLB_ENTRIES];
   logic [PB-1:0] tlb_pp_ff [TLB_ENTRIES];
   logic [2:0]    tlb_r_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] tlb_v_ff, tlb_v_in;
   logic tlb_fill;
   logic [31:0] tr_ff, hit_ff, miss_ff, flt_ff;
   logic [31:0] tr_in, hit_in, miss_in, flt_in;
   logic [2:0] st_ff, st_in;
   logic hitflag_ff, hitflag_in;
   logic out_ff, out_in;
   tlbpt_pkg::pt_cmd_type cmd;
   logic [IB-1:0] addr;
   logic [PB-1:0] rd_vp, rd_pp;
   logic [2:0] rd_r;
   logic rd_p, init_done;
   logic accept;
   logic [TB-1:0] tsel;

   assign accept = start && !busy;
   assign busy = (state_ff != tlbpt_pkg::S_IDLE) || !init_done;
   assign tsel = tidx_ff[TB-1:0];
   assign addr = idx_ff[IB-1:0];

   tlbpt_table #(.TABLE_ENTRIES(TABLE_ENTRIES), .IDX_BITS(IB)) u_table (
      .clock, .reset, .cmd, .addr,
      .wr_vpage(page_ff), .wr_ppage(add_pp_ff), .wr_rights(perm_ff),
      .rd_vpage(rd_vp), .rd_ppage(rd_pp), .rd_rights(rd_r), .rd_present(rd_p),
      .init_done
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlbpt_pkg::S_IDLE;
         tlb_v_ff <= '0;
         next_ff <= '0;
         count_ff <= CB'(tlbpt_pkg::PRESETS);
         tr_ff <= '0; hit_ff <= '0; miss_ff <= '0; flt_ff <= '0;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tlb_v_ff <= tlb_v_in;
         next_ff <= next_in;
         count_ff <= count_in;
         tr_ff <= tr_in; hit_ff <= hit_in; miss_ff <= miss_in; flt_ff <= flt_in;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      tidx_ff <= tidx_in;
      rights_ff <= rights_in;
      res_pp_ff <= res_pp_in;
      st_ff <= st_in;
      hitflag_ff <= hitflag_in;
      if (accept) begin
         kind_ff <= req_kind;
         acc_ff <= req_access;
         page_ff <= (req_kind == tlbpt_pkg::KIND_ADD) ? req_virtual_page
                    : PB'(req_virtual_address >> OFFSET_BITS);
         off_ff <= req_virtual_address[OFFSET_BITS-1:0];
         add_pp_ff <= req_physical_page;
         perm_ff <= req_permissions;
      end
      if (tlb_fill) begin
         tlb_vp_ff[next_ff] <= page_ff;
         tlb_pp_ff[next_ff] <= rd_pp;
         tlb_r_ff[next_ff] <= rd_r;
      end
   end

   always_comb begin
      logic granted;
      state_in = state_ff;
      idx_in = idx_ff;
      tidx_in = tidx_ff;
      rights_in = rights_ff;
      res_pp_in = res_pp_ff;
      st_in = st_ff;
      hitflag_in = hitflag_ff;
      tlb_v_in = tlb_v_ff;
      next_in = next_ff;
      count_in = count_ff;
      tr_in = tr_ff; hit_in = hit_ff; miss_in = miss_ff; flt_in = flt_ff;
      out_in = 1'b0;
      cmd = '0;
      tlb_fill = 1'b0;
      granted = (acc_ff != tlbpt_pkg::ACC_NONE) && rights_ff[acc_ff];
      unique case (state_ff)
         tlbpt_pkg::S_IDLE: begin
            idx_in = '0;
            tidx_in = '0;
            hitflag_in = 1'b0;
            if (accept) begin
               unique case (tlbpt_pkg::kind_type'(req_kind))
                  tlbpt_pkg::KIND_TRANSLATE: begin
                     tr_in = tr_ff + 32'd1;
                     state_in = tlbpt_pkg::S_TLB;
                  end
                  tlbpt_pkg::KIND_ADD: begin
                     if (count_ff >= CB'(TABLE_ENTRIES)) begin
                        st_in = tlbpt_pkg::ST_FULL;
                        state_in = tlbpt_pkg::S_DONE;
                     end else state_in = tlbpt_pkg::S_ADD;
                  end
                  tlbpt_pkg::KIND_FLUSH: begin
                     tlb_v_in = '0;
                     st_in = tlbpt_pkg::ST_FLUSHED;
                     state_in = tlbpt_pkg::S_DONE;
                  end
                  default: ;
               endcase
            end
         end
         tlbpt_pkg::S_TLB: begin
            if (tidx_ff == TCB'(TLB_ENTRIES)) begin
               miss_in = miss_ff + 32'd1;
               state_in = tlbpt_pkg::S_WALK;
            end else if (tlb_v_ff[tsel] && tlb_vp_ff[tsel] == page_ff) begin
               hit_in = hit_ff + 32'd1;
               hitflag_in = 1'b1;
               rights_in = tlb_r_ff[tsel];
               res_pp_in = tlb_pp_ff[tsel];
               state_in = tlbpt_pkg::S_DIRTY;
               idx_in = '0;
            end else tidx_in = tidx_ff + TCB'(1);
         end
         tlbpt_pkg::S_WALK: begin
            if (idx_ff >= count_ff) begin
               flt_in = flt_ff + 32'd1;
               st_in = tlbpt_pkg::ST_FAULT;
               state_in = tlbpt_pkg::S_DONE;
            end else begin
               cmd.rd = 1'b1;
               state_in = tlbpt_pkg::S_WCMP;
            end
         end
         tlbpt_pkg::S_WCMP: begin
            if (rd_vp == page_ff && rd_p) begin
               cmd.set_acc = 1'b1;
               tlb_fill = 1'b1;
               tlb_v_in[next_ff] = 1'b1;
               next_in = (next_ff == TB'(TLB_ENTRIES - 1)) ? '0 : next_ff + TB'(1);
               rights_in = rd_r;
               res_pp_in = rd_pp;
               idx_in = '0;
               state_in = tlbpt_pkg::S_DIRTY;
            end else begin
               idx_in = idx_ff + CB'(1);
               state_in = tlbpt_pkg::S_WALK;
            end
         end
         tlbpt_pkg::S_DIRTY: begin
            if (!granted) begin
               st_in = tlbpt_pkg::ST_DENIED;
               state_in = tlbpt_pkg::S_DONE;
            end else if (acc_ff != tlbpt_pkg::ACC_WRITE || idx_ff >= count_ff) begin
               st_in = tlbpt_pkg::ST_TRANSLATED;
               state_in = tlbpt_pkg::S_DONE;
            end else begin
               cmd.rd = 1'b1;
               state_in = tlbpt_pkg::S_DCMP;
            end
         end
         tlbpt_pkg::S_DCMP: begin
            if (rd_vp == page_ff) begin
               cmd.set_dirty = 1'b1;
               st_in = tlbpt_pkg::ST_TRANSLATED;
               state_in = tlbpt_pkg::S_DONE;
            end else begin
               idx_in = idx_ff + CB'(1);
               state_in = tlbpt_pkg::S_DIRTY;
            end
         end
         tlbpt_pkg::S_ADD: begin
            if (idx_ff >= count_ff) begin
               st_in = tlbpt_pkg::ST_APPENDED;
               count_in = count_ff + CB'(1);
               state_in = tlbpt_pkg::S_ADDW;
            end else begin
               cmd.rd = 1'b1;
               state_in = tlbpt_pkg::S_ACMP;
            end
         end
         tlbpt_pkg::S_ACMP: begin
            if (rd_vp == page_ff) begin
               st_in = tlbpt_pkg::ST_REPLACED;
               tlb_v_in = '0;
               state_in = tlbpt_pkg::S_ADDW;
            end else begin
               idx_in = idx_ff + CB'(1);
               state_in = tlbpt_pkg::S_ADD;
            end
         end
         tlbpt_pkg::S_ADDW: begin
            cmd.wr_entry = 1'b1;
            state_in = tlbpt_pkg::S_DONE;
         end
         tlbpt_pkg::S_DONE: begin
            out_in = 1'b1;
            state_in = tlbpt_pkg::S_IDLE;
         end
         default: state_in = tlbpt_pkg::S_IDLE;
      endcase
   end

   // Result register: loaded when DONE ends, shown for one cycle
   logic [2:0]  o_st_ff;
   logic [47:0] o_pa_ff;
   logic        o_hit_ff;
   always_ff @(posedge clock) begin
      if (state_ff == tlbpt_pkg::S_DONE) begin
         o_st_ff <= st_ff;
         o_hit_ff <= hitflag_ff && (kind_ff == tlbpt_pkg::KIND_TRANSLATE);
         o_pa_ff <= (st_ff == tlbpt_pkg::ST_TRANSLATED && kind_ff == tlbpt_pkg::KIND_TRANSLATE)
                    ? 48'({res_pp_ff, off_ff}) : '0;
      end
   end

   assign rsp_valid = out_ff;
   assign rsp_status = o_st_ff;
   assign rsp_physical_address = o_pa_ff;
   assign rsp_tlb_hit = o_hit_ff;
   assign rsp_translation_count = tr_ff;
   assign rsp_hit_count = hit_ff;
   assign rsp_miss_count = miss_ff;
   assign rsp_fault_count = flt_ff;
endmodule

>>> sv/tlbpt_table.sv
// Linear page table memory: one read or write port, registered read data.
// Preset entries loaded by a short sweep after reset. Uses tlbpt_pkg.
module tlbpt_table #(
   parameter int TABLE_ENTRIES = 128,
   parameter int IDX_BITS = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tlbpt_pkg::pt_cmd_type             cmd,
   input  logic [IDX_BITS-1:0]               addr,
   input  logic [tlbpt_pkg::PAGE_BITS-1:0]   wr_vpage,
   input  logic [tlbpt_pkg::PAGE_BITS-1:0]   wr_ppage,
   input  logic [2:0]                        wr_rights,
   output logic [tlbpt_pkg::PAGE_BITS-1:0]   rd_vpage,
   output logic [tlbpt_pkg::PAGE_BITS-1:0]   rd_ppage,
   output logic [2:0]                        rd_rights,
   output logic                              rd_present,
   output logic                              init_done
);
   localparam int EW = 2*tlbpt_pkg::PAGE_BITS + 3 + 1;
   logic [EW-1:0] mem [TABLE_ENTRIES];
   logic dirty_ff [TABLE_ENTRIES];
   logic acc_ff [TABLE_ENTRIES];
   logic [2:0] init_ff, init_in;
   logic [EW-1:0] rd_ff;

   function automatic logic [tlbpt_pkg::PAGE_BITS-1:0] PAGE_BITS_ext(input logic [2:0] v);
      return {{(tlbpt_pkg::PAGE_BITS-3){1'b0}}, v};
   endfunction

   assign init_done = (init_ff == 3'(tlbpt_pkg::PRESETS));
   assign init_in = init_done ? init_ff : init_ff + 3'd1;

   always_ff @(posedge clock) begin
      if (reset) init_ff <= '0;
      else init_ff <= init_in;
   end

   always_ff @(posedge clock) begin
      if (!init_done) begin
         mem[IDX_BITS'(init_ff)] <= {PAGE_BITS_ext(init_ff), tlbpt_pkg::preset_phys(init_ff),
                                     tlbpt_pkg::preset_rights(init_ff), 1'b1};
         dirty_ff[IDX_BITS'(init_ff)] <= 1'b0;
         acc_ff[IDX_BITS'(init_ff)] <= 1'b0;
      end else if (cmd.wr_entry) begin
         mem[addr] <= {wr_vpage, wr_ppage, wr_rights, 1'b1};
         dirty_ff[addr] <= 1'b0;
         acc_ff[addr] <= 1'b0;
      end else if (cmd.set_acc) begin
         acc_ff[addr] <= 1'b1;
      end else if (cmd.set_dirty) begin
         dirty_ff[addr] <= 1'b1;
      end
      if (cmd.rd) rd_ff <= mem[addr];
   end

   assign rd_vpage   = rd_ff[EW-1 -: tlbpt_pkg::PAGE_BITS];
   assign rd_ppage   = rd_ff[4 +: tlbpt_pkg::PAGE_BITS];
   assign rd_rights  = rd_ff[3:1];
   assign rd_present = rd_ff[0];
endmodule

>>> sv/tlbpt_checker.sv
// Port-level checks for the page translation unit, bound to the top level.
// Depends on tlb_page_translation_unit ports and tlbpt_pkg.
module tlbpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_kind,
   input logic        rsp_valid,
   input logic [2:0]  rsp_status,
   input logic [47:0] rsp_physical_address,
   input logic        rsp_tlb_hit
);
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   // an ignored kind leaves the unit idle
   a_busy_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind != tlbpt_pkg::KIND_NONE) |=> busy)
      else $error("busy not raised after accept");
   a_pa_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != tlbpt_pkg::ST_TRANSLATED) |-> rsp_physical_address == 48'd0)
      else $error("address not zero on failed transaction");
   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tlb_hit) |->
         (rsp_status == tlbpt_pkg::ST_TRANSLATED || rsp_status == tlbpt_pkg::ST_DENIED))
      else $error("hit with non-translate status");
endmodule

bind tlb_page_translation_unit tlbpt_checker u_checker (
   .clock, .reset, .start, .busy, .req_kind, .rsp_valid, .rsp_status,
   .rsp_physical_address, .rsp_tlb_hit
);

>>> sim/tb_top.sv
// Testbench for tlb_page_translation_unit: directed and random transactions,
// checked against an in-bench model of TLB and page table. Depends on tlbpt_pkg.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TLB_N = 16;
   localparam int TBL_N = 128;

   typedef struct {
      logic [1:0]  kind;
      logic [47:0] va;
      logic [1:0]  acc;
      logic [35:0] vp;
      logic [35:0] pp;
      logic [2:0]  perm;
   } txn_type;

   typedef struct {
      logic [2:0]  status;
      logic [47:0] pa;
      logic        hit;
      logic [31:0] n_tr, n_hit, n_miss, n_fault;
   } resp_type;

   logic clock = 0, reset = 1, start = 0;
   logic busy;
   logic [1:0] req_kind = 0, req_access = 0;
   logic [47:0] req_virtual_address = 0;
   logic [35:0] req_virtual_page = 0, req_physical_page = 0;
   logic [2:0] req_permissions = 0;
   logic rsp_valid, rsp_tlb_hit;
   logic [2:0] rsp_status;
   logic [47:0] rsp_physical_address;
   logic [31:0] rsp_translation_count, rsp_hit_count, rsp_miss_count, rsp_fault_count;

   tlb_page_translation_unit uut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // model state
   logic [35:0] m_vp [TBL_N], m_pp [TBL_N];
   logic [2:0]  m_rt [TBL_N];
   int          m_cnt;
   logic [35:0] t_vp [TLB_N], t_pp [TLB_N];
   logic [2:0]  t_rt [TLB_N];
   logic        t_ok [TLB_N];
   int          t_next;
   logic [31:0] c_tr, c_hit, c_miss, c_fault;

   txn_type  pending[$];
   resp_type expected_resp[$];
   int       errors = 0;

   function automatic resp_type translate_model(txn_type t);
      resp_type r;
      logic [35:0] pg, ppg;
      logic [2:0] rt;
      bit found;
      r = '{default: 0};
      found = 0;
      ppg = 0;
      rt = 0;
      case (t.kind)
         tlbpt_pkg::KIND_TRANSLATE: begin
            pg = t.va[47:12];
            c_tr++;
            for (int i = 0; i < TLB_N; i++)
               if (!found && t_ok[i] && t_vp[i] == pg) begin
                  found = 1; ppg = t_pp[i]; rt = t_rt[i];
               end
            if (found) begin
               c_hit++;
               r.hit = 1;
            end else begin
               c_miss++;
               for (int i = 0; i < m_cnt; i++)
                  if (!found && m_vp[i] == pg) begin
                     found = 1; ppg = m_pp[i]; rt = m_rt[i];
                     t_vp[t_next] = pg; t_pp[t_next] = ppg; t_rt[t_next] = rt;
                     t_ok[t_next] = 1;
                     t_next = (t_next + 1) % TLB_N;
                  end
            end
            if (!found) begin
               c_fault++;
               r.status = tlbpt_pkg::ST_FAULT;
            end else if (t.acc == tlbpt_pkg::ACC_NONE || !rt[t.acc]) begin
               r.status = tlbpt_pkg::ST_DENIED;
            end else begin
               r.status = tlbpt_pkg::ST_TRANSLATED;
               r.pa = {ppg, t.va[11:0]};
            end
         end
         tlbpt_pkg::KIND_ADD: begin
            if (m_cnt >= TBL_N) begin
               r.status = tlbpt_pkg::ST_FULL;
            end else begin
               r.status = tlbpt_pkg::ST_APPENDED;
               for (int i = 0; i < m_cnt; i++)
                  if (r.status == tlbpt_pkg::ST_APPENDED && m_vp[i] == t.vp) begin
                     m_pp[i] = t.pp; m_rt[i] = t.perm;
                     for (int j = 0; j < TLB_N; j++) t_ok[j] = 0;
                     r.status = tlbpt_pkg::ST_REPLACED;
                  end
               if (r.status == tlbpt_pkg::ST_APPENDED) begin
                  m_vp[m_cnt] = t.vp; m_pp[m_cnt] = t.pp; m_rt[m_cnt] = t.perm;
                  m_cnt++;
               end
            end
         end
         default: begin
            for (int j = 0; j < TLB_N; j++) t_ok[j] = 0;
            r.status = tlbpt_pkg::ST_FLUSHED;
         end
      endcase
      r.n_tr = c_tr; r.n_hit = c_hit; r.n_miss = c_miss; r.n_fault = c_fault;
      return r;
   endfunction

   // driver
   int gap = 0;
   always @(posedge clock) begin
      txn_type t;
      if (!reset) begin
         if (start && !busy) begin
            t = pending.pop_front();
            if (t.kind != tlbpt_pkg::KIND_NONE) expected_resp.push_back(translate_model(t));
            start <= 0;
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) gap = 0;
         end else if (!start && pending.size() > 0) begin
            if (gap > 0) begin
               gap--;
            end else begin
               t = pending[0];
               req_kind <= t.kind; req_virtual_address <= t.va; req_access <= t.acc;
               req_virtual_page <= t.vp; req_physical_page <= t.pp;
               req_permissions <= t.perm;
               start <= 1;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      resp_type e;
      if (!reset && rsp_valid) begin
         if (expected_resp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response status %0d", rsp_status);
         end else begin
            e = expected_resp.pop_front();
            if (rsp_status !== e.status || rsp_physical_address !== e.pa ||
                rsp_tlb_hit !== e.hit || rsp_translation_count !== e.n_tr ||
                rsp_hit_count !== e.n_hit || rsp_miss_count !== e.n_miss ||
                rsp_fault_count !== e.n_fault) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch exp st=%0d pa=%h h=%0d %0d/%0d/%0d/%0d %s",
                     e.status, e.pa, e.hit, e.n_tr, e.n_hit, e.n_miss, e.n_fault,
                     $sformatf("got st=%0d pa=%h h=%0d %0d/%0d/%0d/%0d",
                        rsp_status, rsp_physical_address, rsp_tlb_hit,
                        rsp_translation_count, rsp_hit_count, rsp_miss_count,
                        rsp_fault_count));
            end
         end
      end
   end

   function automatic txn_type mk(logic [1:0] k, logic [47:0] va, logic [1:0] a,
                                  logic [35:0] vp, logic [35:0] pp, logic [2:0] pm);
      txn_type t;
      t.kind = k; t.va = va; t.acc = a; t.vp = vp; t.pp = pp; t.perm = pm;
      return t;
   endfunction

   // pick a page: mostly known ones so that hits and table walks dominate
   function automatic logic [35:0] pick_page(int cnt);
      logic [35:0] p;
      case ($urandom_range(0, 9))
         0: p = 36'({$urandom, $urandom});
         1: p = 36'hF_FFFF_FFFF;
         default: p = m_vp[$urandom_range(0, cnt - 1)];
      endcase
      return p;
   endfunction

   logic [35:0] shadow_vp [TBL_N];
   int shadow_cnt;

   initial begin
      txn_type t;
      logic [35:0] p;
      int r;
      for (int i = 0; i < TBL_N; i++) begin
         m_vp[i] = 0; m_pp[i] = 0; m_rt[i] = 0; shadow_vp[i] = 0;
      end
      for (int i = 0; i < tlbpt_pkg::PRESETS; i++) begin
         m_vp[i] = 36'(i); shadow_vp[i] = 36'(i);
      end
      m_pp[0] = 36'h30000; m_pp[1] = 36'h21000; m_pp[2] = 36'h45000;
      m_pp[3] = 36'h72000; m_pp[4] = 36'h80000;
      m_rt[0] = 3'b111; m_rt[1] = 3'b011; m_rt[2] = 3'b101; m_rt[3] = 3'b001;
      m_rt[4] = 3'b011;
      m_cnt = tlbpt_pkg::PRESETS; shadow_cnt = tlbpt_pkg::PRESETS;
      for (int j = 0; j < TLB_N; j++) begin
         t_ok[j] = 0; t_vp[j] = 0; t_pp[j] = 0; t_rt[j] = 0;
      end
      t_next = 0; c_tr = 0; c_hit = 0; c_miss = 0; c_fault = 0;

      // directed: every access on presets, fault, access code three, add/replace/flush
      for (int a = 0; a < 4; a++)
         for (int i = 0; i < tlbpt_pkg::PRESETS; i++)
            pending.push_back(mk(tlbpt_pkg::KIND_TRANSLATE, {36'(i), 12'hFFF}, 2'(a),
                                 0, 0, 0));
      pending.push_back(mk(tlbpt_pkg::KIND_TRANSLATE, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0));
      pending.push_back(mk(tlbpt_pkg::KIND_ADD, 0, 0, 36'hF_FFFF_FFFF, 36'hF_FFFF_FFFF,
                           3'b111));
      pending.push_back(mk(tlbpt_pkg::KIND_TRANSLATE, 48'hFFFF_FFFF_FFFF, 2, 0, 0, 0));
      pending.push_back(mk(tlbpt_pkg::KIND_ADD, 0, 0, 36'd1, 36'd0, 3'b000));
      pending.push_back(mk(tlbpt_pkg::KIND_NONE, 48'h1234, 0, 0, 0, 0));
      pending.push_back(mk(tlbpt_pkg::KIND_FLUSH, 0, 0, 0, 0, 0));
      shadow_vp[shadow_cnt++] = 36'hF_FFFF_FFFF;

      // random: adds fill the table partway through so the full case is reached
      for (int n = 0; n < 1600; n++) begin
         r = $urandom_range(0, 99);
         if (r < 8 || (n > 1200 && r < 20)) begin
            if ($urandom_range(0, 3) == 0) p = pick_page(shadow_cnt);
            else p = 36'({$urandom, $urandom});
            t = mk(tlbpt_pkg::KIND_ADD, 0, 0, p, 36'({$urandom, $urandom}),
                   3'($urandom_range(0, 7)));
            if (shadow_cnt < TBL_N) begin
               r = 1;
               for (int i = 0; i < shadow_cnt; i++) if (shadow_vp[i] == p) r = 0;
               if (r) shadow_vp[shadow_cnt++] = p;
            end
         end else if (r < 11) begin
            t = mk(tlbpt_pkg::KIND_FLUSH, 48'({$urandom, $urandom}), 2'($urandom),
                   0, 0, 0);
         end else if (r < 12) begin
            t = mk(tlbpt_pkg::KIND_NONE, 48'({$urandom, $urandom}), 2'($urandom),
                   0, 0, 0);
         end else begin
            p = 0;
            for (int i = 0; i < 1; i++) begin
               case ($urandom_range(0, 9))
                  0: p = 36'({$urandom, $urandom});
                  1: p = 36'hF_FFFF_FFFF;
                  default: p = shadow_vp[$urandom_range(0, shadow_cnt - 1)];
               endcase
            end
            t = mk(tlbpt_pkg::KIND_TRANSLATE, {p, 12'($urandom)}, 2'($urandom_range(0, 3)),
                   36'({$urandom, $urandom}), 36'({$urandom, $urandom}), 3'($urandom));
         end
         pending.push_back(t);
      end

      repeat (11) @(posedge clock);
      reset <= 0;
      while (pending.size() != 0 || expected_resp.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      if (errors == 0 && expected_resp.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   initial begin
      #200ms;
      $display("tb_top: errors");
      $finish;
   end
endmodule
